[rtl/core/usd_pkg.sv]
// ----------------------------------------------------------------------------
// usd_pkg: shared definitions of the UTF-8 stream decoder
// Field widths, offset counter width and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int OFFSET_WIDTH = 32;
    localparam int BYTE_W       = 8;
    localparam int CP_W         = 21;
    localparam int LEN_W        = 3;
    localparam int OUT_OFF_W    = 32;

    typedef struct packed {
        logic load;
        logic emit;
        logic term;
    } t_cmd;

    typedef struct packed {
        logic stop;
        logic span_end;
    } t_status;

endpackage

[rtl/core/usd_if.sv]
// ----------------------------------------------------------------------------
// usd_byte_if / usd_result_if: request channels of the decoder
// Valid and ready handshake with the byte or result payload.
// ----------------------------------------------------------------------------
interface usd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [usd_pkg::BYTE_W-1:0] data_byte;
    logic                       byte_present;
    logic                       span_end;

    modport source (output valid, output data_byte, output byte_present,
                    output span_end, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input span_end, output ready);
endinterface

interface usd_result_if;
    logic                          valid;
    logic                          ready;
    logic [usd_pkg::CP_W-1:0]      code_point;
    logic [usd_pkg::LEN_W-1:0]     byte_length;
    logic [usd_pkg::OUT_OFF_W-1:0] start_offset;
    logic                          is_error;
    logic                          is_terminator;

    modport source (output valid, output code_point, output byte_length,
                    output start_offset, output is_error, output is_terminator,
                    input ready);
    modport sink   (input valid, input code_point, input byte_length,
                    input start_offset, input is_error, input is_terminator,
                    output ready);
endinterface

[rtl/core/usd_datapath.sv]
// ----------------------------------------------------------------------------
// usd_datapath: byte buffer, sequence decoder and result register
// Holds up to four unresolved bytes, decodes the sequence at the front and
// loads one result per emit command and a terminator per term command.
// ----------------------------------------------------------------------------
module usd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  usd_pkg::t_cmd                 i_cmd,
    output usd_pkg::t_status              o_status,
    input  logic [usd_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_byte_present,
    input  logic                          i_span_end,
    output logic [usd_pkg::CP_W-1:0]      o_code_point,
    output logic [usd_pkg::LEN_W-1:0]     o_byte_length,
    output logic [usd_pkg::OUT_OFF_W-1:0] o_start_offset,
    output logic                          o_is_error,
    output logic                          o_is_terminator
);

    localparam logic [usd_pkg::CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [usd_pkg::CP_W-1:0] SURR_LO  = 21'h00D800;
    localparam logic [usd_pkg::CP_W-1:0] SURR_HI  = 21'h00DFFF;
    localparam logic [usd_pkg::CP_W-1:0] MIN_TWO  = 21'h000080;
    localparam logic [usd_pkg::CP_W-1:0] MIN_THR  = 21'h000800;
    localparam logic [usd_pkg::CP_W-1:0] MIN_FOUR = 21'h010000;

    logic [usd_pkg::BYTE_W-1:0]       r_buf [4];
    logic [2:0]                       r_cnt;
    logic [usd_pkg::OFFSET_WIDTH-1:0] r_offset;
    logic                             r_end;

    logic [usd_pkg::CP_W-1:0]      r_code_point;
    logic [usd_pkg::LEN_W-1:0]     r_byte_length;
    logic [usd_pkg::OUT_OFF_W-1:0] r_start_offset;
    logic                          r_is_error;
    logic                          r_is_terminator;

    logic [usd_pkg::BYTE_W-1:0] lead;
    logic                       lead_ok;
    logic [2:0]                 need;
    logic                       short_seq;
    logic                       trails_ok;
    logic                       range_ok;
    logic                       ok;
    logic [2:0]                 take;
    logic [usd_pkg::CP_W-1:0]   cp;
    logic [63:0]                offset_wide;

    always_comb begin
        lead      = r_buf[0];
        lead_ok   = (lead < 8'hF8) && (lead[7:6] != 2'b10);
        if (lead <= 8'h7F) begin
            need = 3'd1;
        end else if (lead <= 8'hDF) begin
            need = 3'd2;
        end else if (lead <= 8'hEF) begin
            need = 3'd3;
        end else begin
            need = 3'd4;
        end
        short_seq = need > r_cnt;
        trails_ok = 1'b0;
        cp        = '0;
        range_ok  = 1'b0;
        case (need)
            3'd1: begin
                trails_ok = 1'b1;
                cp        = {13'd0, lead};
                range_ok  = 1'b1;
            end
            3'd2: begin
                trails_ok = r_buf[1][7:6] == 2'b10;
                cp        = {10'd0, lead[4:0], r_buf[1][5:0]};
                range_ok  = cp >= MIN_TWO;
            end
            3'd3: begin
                trails_ok = (r_buf[1][7:6] == 2'b10) && (r_buf[2][7:6] == 2'b10);
                cp        = {5'd0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
                range_ok  = (cp >= MIN_THR) && !((cp >= SURR_LO) && (cp <= SURR_HI));
            end
            default: begin
                trails_ok = (r_buf[1][7:6] == 2'b10) && (r_buf[2][7:6] == 2'b10)
                            && (r_buf[3][7:6] == 2'b10);
                cp        = {lead[2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
                range_ok  = (cp >= MIN_FOUR) && (cp <= CP_MAX);
            end
        endcase
        ok          = lead_ok && !short_seq && trails_ok && range_ok;
        take        = ok ? need : 3'd1;
        offset_wide = 64'(r_offset);
    end

    assign o_status.stop     = (r_cnt == 3'd0) || (lead_ok && short_seq && !r_end);
    assign o_status.span_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_offset <= '0;
            r_end    <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_byte_present) begin
                r_buf[r_cnt[1:0]] <= i_data_byte;
                r_cnt             <= r_cnt + 3'd1;
            end
            r_end <= i_span_end;
        end else if (i_cmd.emit) begin
            case (take)
                3'd1: begin
                    r_buf[0] <= r_buf[1];
                    r_buf[1] <= r_buf[2];
                    r_buf[2] <= r_buf[3];
                end
                3'd2: begin
                    r_buf[0] <= r_buf[2];
                    r_buf[1] <= r_buf[3];
                end
                3'd3: begin
                    r_buf[0] <= r_buf[3];
                end
                default: begin
                end
            endcase
            r_cnt    <= r_cnt - take;
            r_offset <= r_offset + usd_pkg::OFFSET_WIDTH'(take);
        end else if (i_cmd.term) begin
            r_cnt    <= '0;
            r_offset <= '0;
            r_end    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_code_point    <= ok ? cp : '0;
            r_byte_length   <= take;
            r_start_offset  <= offset_wide[usd_pkg::OUT_OFF_W-1:0];
            r_is_error      <= !ok;
            r_is_terminator <= 1'b0;
        end else if (i_cmd.term) begin
            r_code_point    <= '0;
            r_byte_length   <= '0;
            r_start_offset  <= offset_wide[usd_pkg::OUT_OFF_W-1:0];
            r_is_error      <= 1'b0;
            r_is_terminator <= 1'b1;
        end
    end

    assign o_code_point    = r_code_point;
    assign o_byte_length   = r_byte_length;
    assign o_start_offset  = r_start_offset;
    assign o_is_error      = r_is_error;
    assign o_is_terminator = r_is_terminator;

endmodule

[rtl/core/usd_controller.sv]
// ----------------------------------------------------------------------------
// usd_controller: sequencing of the UTF-8 stream decoder
// Accepts bytes, steps the datapath through the pending sequences and
// closes each span with a terminator.
// ----------------------------------------------------------------------------
module usd_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output usd_pkg::t_cmd    o_cmd,
    input  usd_pkg::t_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TERM
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.stop) begin
                    if (i_status.span_end) begin
                        n_state = ST_TERM;
                    end else begin
                        o_in_ready = 1'b1;
                        if (i_in_valid) begin
                            o_cmd.load = 1'b1;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    o_cmd.term = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.emit || o_cmd.term) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_emit_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_status.stop)
        else $error("emit issued while the buffer holds no decodable sequence");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_cmd.emit || o_cmd.term))
        else $error("result register overwritten while stalled");

    a_term_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.term |=> (r_out_valid && r_state == ST_IDLE))
        else $error("terminator not presented after span end");

    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !(o_cmd.emit || o_cmd.term))
        else $error("byte loaded while the buffer is being consumed");

endmodule

[rtl/core/utf8_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: streaming UTF-8 decoder
// Turns a byte stream into code points with length and start offset.
// ----------------------------------------------------------------------------
// Bytes arrive on i_byte_ch, one request per byte; a request with
// byte_present low and span_end high closes an empty span. Each decoded
// code point, each one-byte error and the terminator of a span leave on
// o_result_ch as one request each.
// An accepted byte enters the byte buffer, the sequence at its front is
// decoded combinationally, and each emit loads the result register. The
// controller emits one result per cycle from the byte buffer while the
// result register is free; a rejected sequence gives up only its lead
// byte as an error, and the pending bytes are scanned again. A span end
// sends the controller to the terminator state, which then emits the
// terminator. Input is taken only while no buffered sequence can still be
// decoded, since the four-byte buffer must drain first.
// After reset the buffer is empty and the offset is zero. When the receiver
// stalls, the result register holds its request and decoding pauses, and
// no further byte is taken until the pending bytes are resolved.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    usd_byte_if.sink      i_byte_ch,
    usd_result_if.source  o_result_ch
);

    usd_pkg::t_cmd    cmd;
    usd_pkg::t_status status;

    usd_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_byte_ch.valid),
        .o_in_ready  (i_byte_ch.ready),
        .o_out_valid (o_result_ch.valid),
        .i_out_ready (o_result_ch.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    usd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_data_byte     (i_byte_ch.data_byte),
        .i_byte_present  (i_byte_ch.byte_present),
        .i_span_end      (i_byte_ch.span_end),
        .o_code_point    (o_result_ch.code_point),
        .o_byte_length   (o_result_ch.byte_length),
        .o_start_offset  (o_result_ch.start_offset),
        .o_is_error      (o_result_ch.is_error),
        .o_is_terminator (o_result_ch.is_terminator)
    );

endmodule

[tb/usd_decode_checker.sv]
// ----------------------------------------------------------------------------
// usd_decode_checker: result predictor and comparator of the UTF-8 decoder
// Watches both request channels. Each accepted byte request is decoded by
// an independent UTF-8 model, and the predicted results are queued. Each
// accepted result request is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module usd_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    usd_byte_if         i_byte_ch,
    usd_result_if       i_result_ch,
    output int unsigned o_mismatch_count,
    output int unsigned o_pending_results
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [usd_pkg::CP_W-1:0]      code_point;
        logic [usd_pkg::LEN_W-1:0]     byte_length;
        logic [usd_pkg::OUT_OFF_W-1:0] start_offset;
        logic                          is_error;
        logic                          is_terminator;
    } t_decoded;

    t_decoded                         expected_results[$];
    logic [usd_pkg::BYTE_W-1:0]       held_bytes [3];
    int unsigned                      held_count;
    logic [usd_pkg::OFFSET_WIDTH-1:0] next_offset;

    function automatic void push_result(input int unsigned cp, input int unsigned len,
                                        input logic err, input logic term);
        t_decoded r;
        r.code_point    = usd_pkg::CP_W'(cp);
        r.byte_length   = usd_pkg::LEN_W'(len);
        r.start_offset  = usd_pkg::OUT_OFF_W'(next_offset);
        r.is_error      = err;
        r.is_terminator = term;
        expected_results.push_back(r);
    endfunction

    function automatic void decode_request(input logic [usd_pkg::BYTE_W-1:0] data,
                                           input logic present, input logic last);
        logic [usd_pkg::BYTE_W-1:0] win [4];
        int unsigned                cnt;
        int unsigned                need;
        int unsigned                take;
        int unsigned                cp;
        int unsigned                min_cp;
        int unsigned                k;
        logic                       valid_seq;
        logic                       trails;
        cnt = held_count;
        for (k = 0; k < cnt; k++) win[k] = held_bytes[k];
        if (present) begin
            win[cnt] = data;
            cnt++;
        end
        while (cnt > 0) begin
            valid_seq = 1'b0;
            take      = 1;
            cp        = 0;
            if (win[0] < 8'hF8 && win[0][7:6] != 2'b10) begin
                if (win[0] <= 8'h7F) begin
                    need = 1; cp = 32'(win[0]); min_cp = 0;
                end else if (win[0] <= 8'hDF) begin
                    need = 2; cp = 32'(win[0] & 8'h1F); min_cp = 'h80;
                end else if (win[0] <= 8'hEF) begin
                    need = 3; cp = 32'(win[0] & 8'h0F); min_cp = 'h800;
                end else begin
                    need = 4; cp = 32'(win[0] & 8'h07); min_cp = 'h10000;
                end
                if (need > cnt) begin
                    if (!last) break;
                end else begin
                    trails = 1'b1;
                    for (k = 1; k < need; k++) begin
                        if (win[k][7:6] != 2'b10) trails = 1'b0;
                        cp = (cp << 6) | 32'(win[k][5:0]);
                    end
                    if (trails && cp >= min_cp && cp <= 'h10FFFF &&
                        !(cp >= 'hD800 && cp <= 'hDFFF)) begin
                        valid_seq = 1'b1;
                        take      = need;
                    end
                end
            end
            if (valid_seq) push_result(cp, take, 1'b0, 1'b0);
            else push_result(0, 1, 1'b1, 1'b0);
            for (k = take; k < cnt; k++) win[k - take] = win[k];
            cnt         = cnt - take;
            next_offset = next_offset + usd_pkg::OFFSET_WIDTH'(take);
        end
        if (last) begin
            push_result(0, 0, 1'b0, 1'b1);
            cnt         = 0;
            next_offset = '0;
        end
        for (k = 0; k < cnt; k++) held_bytes[k] = win[k];
        held_count = cnt;
    endfunction

    initial begin
        o_mismatch_count  = 0;
        o_pending_results = 0;
        held_count        = 0;
        next_offset       = '0;
    end

    always @(posedge i_clk) begin : compare
        t_decoded seen;
        t_decoded want;
        if (!i_rst_n) begin
            expected_results.delete();
            held_count       = 0;
            next_offset      = '0;
            o_mismatch_count = 0;
        end else begin
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                decode_request(i_byte_ch.data_byte, i_byte_ch.byte_present,
                               i_byte_ch.span_end);
            end
            if (i_result_ch.valid && i_result_ch.ready) begin
                seen = {i_result_ch.code_point, i_result_ch.byte_length,
                        i_result_ch.start_offset, i_result_ch.is_error,
                        i_result_ch.is_terminator};
                if (expected_results.size() == 0) begin
                    if (o_mismatch_count < MAX_REPORTS) begin
                        $display("%0t: unexpected result cp=%06h len=%0d off=%0d err=%0b term=%0b",
                                 $time, seen.code_point, seen.byte_length,
                                 seen.start_offset, seen.is_error, seen.is_terminator);
                    end
                    o_mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.code_point !== want.code_point ||
                        seen.byte_length !== want.byte_length ||
                        seen.start_offset !== want.start_offset ||
                        seen.is_error !== want.is_error ||
                        seen.is_terminator !== want.is_terminator) begin
                        if (o_mismatch_count < MAX_REPORTS) begin
                            $display("%0t: expected cp=%06h len=%0d off=%0d err=%0b term=%0b",
                                     $time, want.code_point, want.byte_length,
                                     want.start_offset, want.is_error, want.is_terminator);
                            $display("%0t:      got cp=%06h len=%0d off=%0d err=%0b term=%0b",
                                     $time, seen.code_point, seen.byte_length,
                                     seen.start_offset, seen.is_error, seen.is_terminator);
                        end
                        o_mismatch_count++;
                    end
                end
            end
        end
        o_pending_results = expected_results.size();
    end

endmodule

[tb/tb_utf8_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit: testbench of the UTF-8 stream decoder
// Sends a directed set of byte spans covering the code point limits and
// every kind of rejected sequence, then random spans made mostly of valid
// UTF-8 text with injected faults. Both channels idle at random; the
// checker predicts and compares every result request.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_unit;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 140;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        NOISE_RANDOM,
        NOISE_STRAY_TRAIL,
        NOISE_TRUNCATED,
        NOISE_OVERLONG,
        NOISE_SURROGATE,
        NOISE_TOO_LARGE
    } t_noise;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned item_count;
    int unsigned idle_cycles;
    logic        send_burst;
    logic        sink_burst;
    logic [7:0]  span_bytes[$];

    usd_byte_if   byte_ch ();
    usd_result_if result_ch ();

    utf8_stream_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_result_ch (result_ch)
    );

    usd_decode_checker u_decode_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_byte_ch         (byte_ch),
        .i_result_ch       (result_ch),
        .o_mismatch_count  (mismatch_count),
        .o_pending_results (pending_results)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] random_trail();
        return 8'h80 | 8'($urandom_range(63, 0));
    endfunction

    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            span_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            span_bytes.push_back({3'b110, cp[10:6]});
            span_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            span_bytes.push_back({4'b1110, cp[15:12]});
            span_bytes.push_back({2'b10, cp[11:6]});
            span_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            span_bytes.push_back({5'b11110, cp[20:18]});
            span_bytes.push_back({2'b10, cp[17:12]});
            span_bytes.push_back({2'b10, cp[11:6]});
            span_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] random_code_point();
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: begin lo = 21'h0;     hi = 21'h7F;     end
            4, 5:       begin lo = 21'h80;    hi = 21'h7FF;    end
            6, 7:       begin lo = 21'h800;   hi = 21'hFFFF;   end
            default:    begin lo = 21'h10000; hi = 21'h10FFFF; end
        endcase
        case ($urandom_range(7, 0))
            0:       cp = lo;
            1:       cp = hi;
            default: cp = 21'($urandom_range(hi, lo));
        endcase
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
        return cp;
    endfunction

    function automatic void push_noise();
        t_noise kind;
        kind = t_noise'($urandom_range(NOISE_TOO_LARGE, NOISE_RANDOM));
        case (kind)
            NOISE_RANDOM: span_bytes.push_back(8'($urandom_range(255, 0)));
            NOISE_STRAY_TRAIL: span_bytes.push_back(random_trail());
            NOISE_TRUNCATED: begin
                push_utf8(random_code_point() | 21'h80);
                void'(span_bytes.pop_back());
            end
            NOISE_OVERLONG: begin
                case ($urandom_range(2, 0))
                    0: span_bytes.push_back(8'hC0 | 8'($urandom_range(1, 0)));
                    1: begin
                        span_bytes.push_back(8'hE0);
                        span_bytes.push_back(8'h80 | 8'($urandom_range(31, 0)));
                    end
                    default: begin
                        span_bytes.push_back(8'hF0);
                        span_bytes.push_back(8'h80 | 8'($urandom_range(15, 0)));
                        span_bytes.push_back(random_trail());
                    end
                endcase
                span_bytes.push_back(random_trail());
            end
            NOISE_SURROGATE: begin
                span_bytes.push_back(8'hED);
                span_bytes.push_back(8'hA0 | 8'($urandom_range(31, 0)));
                span_bytes.push_back(random_trail());
            end
            default: begin
                if ($urandom_range(1, 0) == 0) begin
                    span_bytes.push_back(8'hF4);
                    span_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
                end else begin
                    span_bytes.push_back(8'($urandom_range(8'hF7, 8'hF5)));
                    span_bytes.push_back(random_trail());
                end
                span_bytes.push_back(random_trail());
                span_bytes.push_back(random_trail());
            end
        endcase
    endfunction

    task automatic send_request(input logic [7:0] data, input logic present,
                                input logic last);
        int unsigned gap;
        if ($urandom_range(19, 0) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(MAX_WAIT, 0);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= data;
        byte_ch.byte_present <= present;
        byte_ch.span_end     <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        if (present || last) item_count++;
    endtask

    task automatic send_span();
        int unsigned n_chars;
        int unsigned k;
        logic        split_end;
        span_bytes.delete();
        n_chars = ($urandom_range(7, 0) == 0) ? $urandom_range(1, 0) : $urandom_range(12, 2);
        for (k = 0; k < n_chars; k++) begin
            if ($urandom_range(9, 0) == 0) push_noise();
            else push_utf8(random_code_point());
        end
        split_end = (span_bytes.size() == 0) || ($urandom_range(3, 0) == 0);
        for (k = 0; k < span_bytes.size(); k++) begin
            if ($urandom_range(24, 0) == 0) send_request(8'($urandom_range(255, 0)), 1'b0, 1'b0);
            send_request(span_bytes[k], 1'b1, !split_end && k == span_bytes.size() - 1);
        end
        if (split_end) send_request(8'($urandom_range(255, 0)), 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    initial begin : result_sink
        int unsigned stall;
        result_ch.ready = 1'b0;
        sink_burst      = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if ($urandom_range(19, 0) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(MAX_WAIT, 0);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned random_base;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'h00;
        byte_ch.byte_present = 1'b0;
        byte_ch.span_end     = 1'b0;
        send_burst           = 1'b0;
        item_count           = 0;
        idle_cycles          = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A request without a byte and without a span end is ignored,
        // and the next one closes an empty span.
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h7F, 1'b1, 1'b0);
        send_request(8'hC2, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'hC0, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'hED, 1'b1, 1'b0);
        send_request(8'hA0, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'hF4, 1'b1, 1'b0);
        send_request(8'h90, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'hF8, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hE2, 1'b1, 1'b0);
        send_request(8'h41, 1'b1, 1'b0);
        send_request(8'hF4, 1'b1, 1'b0);
        send_request(8'h8F, 1'b1, 1'b0);
        send_request(8'hBF, 1'b1, 1'b0);
        send_request(8'hBF, 1'b1, 1'b0);
        // An unfinished sequence at the span end is flushed as errors.
        send_request(8'hF0, 1'b1, 1'b0);
        send_request(8'h9F, 1'b1, 1'b1);
        drain_results();

        random_base = item_count;
        while (item_count < random_base + RANDOM_ITEMS / 2) send_span();
        drain_results();
        while (item_count < random_base + RANDOM_ITEMS) send_span();

        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
